>>> rtl/crmtd_pkg.sv
// Shared types and constants for the crank missing-tooth decoder.
package crmtd_pkg;

  // Divider operand widths: the rpm numerator fits in 26 bits and the
  // divisor is a 32 bit period times an 8 bit tooth count.
  localparam int DIV_DVD_W = 26;
  localparam int DIV_DSR_W = 40;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 10;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [DIV_DVD_W-1:0] RPM_NUMERATOR = 26'd60000000;
  localparam logic [MUL_B_W-1:0]   PCT_SCALE     = 10'd100;
  localparam logic [15:0]          RPM_MAX       = 16'hFFFF;
  localparam logic [7:0]           COUNT_MAX     = 8'hFF;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PERIOD = 3'd0,
    CFG_GAP_RATIO  = 3'd1,
    CFG_GAPS_SYNC  = 3'd2,
    CFG_EFF_TEETH  = 3'd3,
    CFG_TEETH_REV  = 3'd4
  } crmtd_cfg_idx_t;

  // Request into the shared divider.
  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
  } crmtd_div_req_t;

  // Status and result from the shared divider.
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
  } crmtd_div_rsp_t;

endpackage

>>> rtl/crank_missing_tooth_decoder_core.sv
// Top level of the crank missing-tooth decoder: sequencer, state and ports.
//
//  Channel | Direction | Handshake        | Beat contents
//  --------+-----------+------------------+-----------------------------------------
//  in_     | in        | in_valid/in_stall | tooth_time, one edge timestamp
//  out_    | out       | out_valid/out_stall | accepted, gap_seen, tooth_index,
//          |           |                  | in_sync, sync_gained, sync_dropped, rpm
//  cfg_    | in        | cfg_valid/cfg_ready | register index and write data
//
// A rejected edge passes the check and finish states before the next edge can
// be taken; an accepted edge out of sync also passes the ratio and update
// states, and one in sync the divisor, divide, wait, history and average states:
// one pass through the shared 26-step restoring divider for the raw rpm, then
// a history average by multiply with the reciprocal of the history depth.
// Reset is synchronous and active low; it clears the sync state, counters,
// history valid bits and the running history sum, and loads register defaults.
// A result beat stalled on out_stall sits in the output register while the
// next edge is already taken; the sequencer only waits if that register is
// still full when the following result is ready.
module crank_missing_tooth_decoder_core
  import crmtd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_tooth_time,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_accepted,
  output logic                 out_gap_seen,
  output logic [7:0]           out_tooth_index,
  output logic                 out_in_sync,
  output logic                 out_sync_gained,
  output logic                 out_sync_dropped,
  output logic [15:0]          out_engine_rpm,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int PosW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SumW = 16 + $clog2(HISTORY_DEPTH);
  localparam logic [PosW-1:0] POS_LAST = PosW'(HISTORY_DEPTH - 1);

  // The average is sum * AVG_MUL >> AvgShift, where AVG_MUL is the reciprocal
  // of the depth rounded up. The extra shift bits keep it exact for every sum.
  localparam int AvgShift = SumW + $clog2(HISTORY_DEPTH);
  localparam int AvgMulW  = SumW + 1;
  localparam int AvgProdW = SumW + AvgMulW;
  localparam logic [AvgMulW-1:0] AVG_MUL =
    AvgMulW'(((64'd1 << AvgShift) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RATIO,
    ST_UPDATE,
    ST_DEN,
    ST_DIV_RPM,
    ST_WAIT_RPM,
    ST_HIST,
    ST_AVG,
    ST_FINISH
  } state_t;

  // Configuration registers.
  logic [15:0] min_period_r;
  logic [9:0]  gap_ratio_r;
  logic [7:0]  gaps_sync_r;
  logic [7:0]  eff_teeth_r;
  logic [7:0]  teeth_rev_r;

  // Decoder state.
  logic [31:0] last_edge_r;
  logic [31:0] prev_period_r;
  logic [7:0]  tooth_cnt_r;
  logic [7:0]  gap_cnt_r;
  logic        sync_r;
  logic [15:0] rpm_r;
  logic [PosW-1:0]          hist_pos_r;
  logic [HISTORY_DEPTH-1:0] hist_vld_r;
  logic [SumW-1:0]          hist_sum_r;

  // Per-edge working registers.
  state_t      state_r;
  logic [31:0] time_r;
  logic [31:0] period_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] lhs_r;
  logic [15:0] raw_r;
  logic        acc_r;
  logic        gap_r;
  logic        gained_r;
  logic        dropped_r;

  // Output register.
  logic        out_valid_r;
  logic        o_acc_r;
  logic        o_gap_r;
  logic [7:0]  o_tooth_r;
  logic        o_sync_r;
  logic        o_gained_r;
  logic        o_dropped_r;
  logic [15:0] o_rpm_r;

  logic              in_take;
  logic              out_take;
  logic              out_free;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  product;
  logic              gap_det;
  logic [7:0]        tooth_inc;
  logic [7:0]        gap_inc;
  logic              sync_upd;
  logic [15:0]       hist_old;
  logic [SumW-1:0]   hist_sum_nxt;
  logic [AvgProdW-1:0] avg_prod;
  logic [15:0]       ram_rdata;

  crmtd_div_req_t div_req;
  crmtd_div_rsp_t div_rsp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // One multiplier is shared by the gap test and the rpm divisor.
  always_comb begin
    case (state_r)
      ST_CHECK: begin
        mul_a = period_r;
        mul_b = PCT_SCALE;
      end
      ST_RATIO: begin
        mul_a = prev_period_r;
        mul_b = gap_ratio_r;
      end
      ST_DEN: begin
        mul_a = period_r;
        mul_b = {2'b00, teeth_rev_r};
      end
      default: begin
        mul_a = period_r;
        mul_b = '0;
      end
    endcase
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Gap and tooth bookkeeping. The gap test compares period*100, held in
  // lhs_r, against prev_period*gap_ratio in prod_r, both at full width.
  assign gap_det   = (prev_period_r != '0) && (lhs_r > prod_r);
  assign tooth_inc = (tooth_cnt_r != COUNT_MAX) ? tooth_cnt_r + 8'd1 : tooth_cnt_r;
  assign gap_inc   = (gap_cnt_r != COUNT_MAX) ? gap_cnt_r + 8'd1 : gap_cnt_r;

  always_comb begin
    if (gap_det) begin
      sync_upd = sync_r || (gap_inc >= gaps_sync_r);
    end else if (tooth_inc >= eff_teeth_r) begin
      sync_upd = 1'b0;
    end else begin
      sync_upd = sync_r;
    end
  end

  // History entries never written since reset read as zero. The running
  // sum drops the entry being replaced and adds the new raw rpm.
  assign hist_old     = hist_vld_r[hist_pos_r] ? ram_rdata : 16'd0;
  assign hist_sum_nxt = hist_sum_r - SumW'(hist_old) + SumW'(raw_r);

  // Average of the history, taken from the registered running sum.
  assign avg_prod = AvgProdW'(hist_sum_r) * AvgProdW'(AVG_MUL);

  crmtd_ram #(
    .Width (16),
    .Depth (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (state_r == ST_HIST),
    .waddr (hist_pos_r),
    .wdata (raw_r),
    .raddr (hist_pos_r),
    .rdata (ram_rdata)
  );

  // A zero divisor makes the divider return all ones, which saturates to
  // the rpm maximum just like an oversize quotient.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = RPM_NUMERATOR;
    div_req.divisor  = prod_r[DIV_DSR_W-1:0];
    case (state_r)
      ST_DIV_RPM: begin
        div_req.start = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  crmtd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= 16'd190;
      gap_ratio_r  <= 10'd150;
      gaps_sync_r  <= 8'd2;
      eff_teeth_r  <= 8'd35;
      teeth_rev_r  <= 8'd36;
    end else if (cfg_valid && cfg_ready) begin
      case (crmtd_cfg_idx_t'(cfg_index))
        CFG_MIN_PERIOD: min_period_r <= cfg_data;
        CFG_GAP_RATIO:  gap_ratio_r  <= cfg_data[9:0];
        CFG_GAPS_SYNC:  gaps_sync_r  <= cfg_data[7:0];
        CFG_EFF_TEETH:  eff_teeth_r  <= cfg_data[7:0];
        CFG_TEETH_REV:  teeth_rev_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer with decoder state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_edge_r   <= '0;
      prev_period_r <= '0;
      tooth_cnt_r   <= '0;
      gap_cnt_r     <= '0;
      sync_r        <= 1'b0;
      rpm_r         <= '0;
      hist_pos_r    <= '0;
      hist_vld_r    <= '0;
      hist_sum_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // The finish state reloads the output register itself when it frees up.
      if (out_take && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            time_r    <= in_tooth_time;
            period_r  <= in_tooth_time - last_edge_r;
            acc_r     <= 1'b0;
            gap_r     <= 1'b0;
            gained_r  <= 1'b0;
            dropped_r <= 1'b0;
            state_r   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          prod_r <= product;
          if (period_r >= {16'd0, min_period_r}) begin
            acc_r   <= 1'b1;
            state_r <= ST_RATIO;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_RATIO: begin
          lhs_r   <= prod_r;
          prod_r  <= product;
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          gap_r         <= gap_det;
          prev_period_r <= period_r;
          last_edge_r   <= time_r;
          sync_r        <= sync_upd;
          if (gap_det) begin
            tooth_cnt_r <= '0;
            gap_cnt_r   <= gap_inc;
            gained_r    <= sync_upd && !sync_r;
          end else if (tooth_inc >= eff_teeth_r) begin
            tooth_cnt_r <= '0;
            gap_cnt_r   <= '0;
            dropped_r   <= sync_r;
          end else begin
            tooth_cnt_r <= tooth_inc;
          end
          state_r <= sync_upd ? ST_DEN : ST_FINISH;
        end
        ST_DEN: begin
          prod_r  <= product;
          state_r <= ST_DIV_RPM;
        end
        ST_DIV_RPM: begin
          state_r <= ST_WAIT_RPM;
        end
        ST_WAIT_RPM: begin
          if (div_rsp.done) begin
            raw_r   <= (|div_rsp.quotient[DIV_DVD_W-1:16]) ? RPM_MAX
                                                           : div_rsp.quotient[15:0];
            state_r <= ST_HIST;
          end
        end
        ST_HIST: begin
          hist_sum_r             <= hist_sum_nxt;
          hist_vld_r[hist_pos_r] <= 1'b1;
          hist_pos_r             <= (hist_pos_r == POS_LAST) ? '0 : hist_pos_r + PosW'(1);
          state_r                <= ST_AVG;
        end
        ST_AVG: begin
          rpm_r   <= avg_prod[AvgShift +: 16];
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_acc_r     <= acc_r;
            o_gap_r     <= gap_r;
            o_tooth_r   <= tooth_cnt_r;
            o_sync_r    <= sync_r;
            o_gained_r  <= gained_r;
            o_dropped_r <= dropped_r;
            o_rpm_r     <= rpm_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = o_acc_r;
  assign out_gap_seen     = o_gap_r;
  assign out_tooth_index  = o_tooth_r;
  assign out_in_sync      = o_sync_r;
  assign out_sync_gained  = o_gained_r;
  assign out_sync_dropped = o_dropped_r;
  assign out_engine_rpm   = o_rpm_r;

  // A beat can never report both gaining and losing sync.
  a_gain_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_sync_gained && out_sync_dropped))
    else $error("sync gained and dropped on the same beat");

  // A rejected edge carries no gap and no sync event.
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> !(out_gap_seen || out_sync_gained || out_sync_dropped))
    else $error("rejected edge reports an event");

  // A gap always restarts the tooth index.
  a_gap_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_gap_seen) |-> (out_tooth_index == 8'd0))
    else $error("gap with nonzero tooth index");

  // Gaining sync leaves the decoder in sync.
  a_gain_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sync_gained) |-> out_in_sync)
    else $error("sync gained but not in sync");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

>>> rtl/crmtd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module crmtd_ram #(
  parameter int Width = 16,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/crmtd_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module crmtd_div
  import crmtd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  crmtd_div_req_t req,
  output crmtd_div_rsp_t rsp
);

  localparam int CntW = $clog2(DIV_DVD_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CntW-1:0]      cnt_r;
  logic [DIV_DVD_W-1:0] quo_r;
  logic [DIV_DSR_W-1:0] dsr_r;
  logic [DIV_DSR_W:0]   rem_r;
  logic [DIV_DSR_W:0]   trial;
  logic                 fits;

  // The quotient register starts out holding the dividend and shifts its
  // bits out at the top while quotient bits enter at the bottom.
  assign trial = {rem_r[DIV_DSR_W-1:0], quo_r[DIV_DVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= CntW'(DIV_DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? (trial - {1'b0, dsr_r}) : trial;
        quo_r <= {quo_r[DIV_DVD_W-2:0], fits};
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> tb/sv/crank_missing_tooth_decoder_core_tb.sv
// Self-checking testbench for the crank missing-tooth decoder core.
`timescale 1ns / 100ps

module crank_missing_tooth_decoder_core_tb
  import crmtd_pkg::*;
();

  localparam int HISTORY_DEPTH = 8;
  // The receiver's long hold-off, in cycles, used to back the block up.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any beat on any channel before the run is declared hung.
  // The worst honest gap is the hold-off plus one in-sync edge, so this
  // leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settling time after the last result before registers are rewritten,
  // and the longer tail at the very end of the run.
  localparam int SETTLE_CYCLES = 8;
  localparam int END_TAIL = 80;

  // One result beat, field for field as it leaves the block.
  typedef struct packed {
    logic        accepted;
    logic        gap_seen;
    logic [7:0]  tooth_index;
    logic        in_sync;
    logic        sync_gained;
    logic        sync_dropped;
    logic [15:0] engine_rpm;
  } tooth_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [31:0]          in_tooth_time;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_accepted;
  logic                 out_gap_seen;
  logic [7:0]           out_tooth_index;
  logic                 out_in_sync;
  logic                 out_sync_gained;
  logic                 out_sync_dropped;
  logic [15:0]          out_engine_rpm;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  crank_missing_tooth_decoder_core #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tooth_time   (in_tooth_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_gap_seen    (out_gap_seen),
    .out_tooth_index (out_tooth_index),
    .out_in_sync     (out_in_sync),
    .out_sync_gained (out_sync_gained),
    .out_sync_dropped(out_sync_dropped),
    .out_engine_rpm  (out_engine_rpm),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Expected result beats, oldest first, one per edge the block has taken.
  tooth_result_t expected_results[$];
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;

  // Idle rates of the two sides in percent, and the request for a hold-off.
  int unsigned src_idle_pct = 27;
  int unsigned sink_idle_pct = 27;
  bit          hold_req = 1'b0;

  // Our own copy of the decoder registers, updated on every config beat.
  logic [15:0] r_min_period;
  logic [9:0]  r_gap_ratio;
  logic [7:0]  r_gaps_sync;
  logic [7:0]  r_eff_teeth;
  logic [7:0]  r_teeth_rev;

  // Our own copy of the decoder state.
  logic [31:0] m_last_time;
  logic [31:0] m_prev_period;
  logic [7:0]  m_tooth_cnt;
  logic [7:0]  m_gap_cnt;
  logic        m_synced;
  logic [15:0] m_rpm_hist[HISTORY_DEPTH];
  int          m_hist_pos;
  logic [15:0] m_rpm;

  // Runs one tooth edge through the decoder state and returns the beat that
  // the block must produce for it. Rejected edges leave every state alone.
  function automatic tooth_result_t decode_tooth(input logic [31:0] stamp);
    tooth_result_t res;
    logic [31:0]   period;
    logic [63:0]   wide_period, wide_prev, divisor, raw_rpm, hist_sum;
    res = '0;
    period = stamp - m_last_time;
    if (period >= r_min_period) begin
      res.accepted = 1'b1;
      wide_period = 64'(period);
      wide_prev = 64'(m_prev_period);
      // Both sides of the gap test are kept at full width.
      if (m_prev_period != 32'd0)
        res.gap_seen = (wide_period * PCT_SCALE) > (wide_prev * r_gap_ratio);
      m_prev_period = period;
      m_last_time = stamp;
      if (res.gap_seen) begin
        m_tooth_cnt = 8'd0;
        if (m_gap_cnt != COUNT_MAX)
          m_gap_cnt = m_gap_cnt + 8'd1;
        if (m_gap_cnt >= r_gaps_sync && !m_synced) begin
          m_synced = 1'b1;
          res.sync_gained = 1'b1;
        end
      end else begin
        if (m_tooth_cnt != COUNT_MAX)
          m_tooth_cnt = m_tooth_cnt + 8'd1;
        if (m_tooth_cnt >= r_eff_teeth) begin
          if (m_synced) begin
            m_synced = 1'b0;
            res.sync_dropped = 1'b1;
          end
          m_tooth_cnt = 8'd0;
          m_gap_cnt = 8'd0;
        end
      end
      if (m_synced) begin
        // A zero divisor reads as the top rpm, as does any overflow.
        divisor = wide_period * r_teeth_rev;
        raw_rpm = (divisor == 64'd0) ? 64'(RPM_MAX) : 64'(RPM_NUMERATOR) / divisor;
        if (raw_rpm > 64'(RPM_MAX))
          raw_rpm = 64'(RPM_MAX);
        m_rpm_hist[m_hist_pos] = raw_rpm[15:0];
        m_hist_pos = (m_hist_pos + 1) % HISTORY_DEPTH;
        hist_sum = 64'd0;
        foreach (m_rpm_hist[i])
          hist_sum = hist_sum + m_rpm_hist[i];
        hist_sum = hist_sum / HISTORY_DEPTH;
        m_rpm = hist_sum[15:0];
      end
    end
    res.tooth_index = m_tooth_cnt;
    res.in_sync = m_synced;
    res.engine_rpm = m_rpm;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // All three channels are observed at the same clock edge, in a fixed order:
  // register writes, then accepted edges, then result beats. Everything read
  // here is the value from before the edge, so no ordering race arises.
  always @(posedge clk) begin : scoreboard
    tooth_result_t want, got;
    if (!rst_n) begin
      r_min_period = 16'd190;
      r_gap_ratio = 10'd150;
      r_gaps_sync = 8'd2;
      r_eff_teeth = 8'd35;
      r_teeth_rev = 8'd36;
      m_last_time = '0;
      m_prev_period = '0;
      m_tooth_cnt = '0;
      m_gap_cnt = '0;
      m_synced = 1'b0;
      foreach (m_rpm_hist[i])
        m_rpm_hist[i] = '0;
      m_hist_pos = 0;
      m_rpm = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_PERIOD: r_min_period = cfg_data;
          CFG_GAP_RATIO:  r_gap_ratio = cfg_data[9:0];
          CFG_GAPS_SYNC:  r_gaps_sync = cfg_data[7:0];
          CFG_EFF_TEETH:  r_eff_teeth = cfg_data[7:0];
          CFG_TEETH_REV:  r_teeth_rev = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_results.push_back(decode_tooth(in_tooth_time));
      if (out_valid && !out_stall) begin
        got.accepted = out_accepted;
        got.gap_seen = out_gap_seen;
        got.tooth_index = out_tooth_index;
        got.in_sync = out_in_sync;
        got.sync_gained = out_sync_gained;
        got.sync_dropped = out_sync_dropped;
        got.engine_rpm = out_engine_rpm;
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no tooth edge pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("gap_seen", 32'(want.gap_seen), 32'(got.gap_seen));
          check_field("tooth_index", 32'(want.tooth_index), 32'(got.tooth_index));
          check_field("in_sync", 32'(want.in_sync), 32'(got.in_sync));
          check_field("sync_gained", 32'(want.sync_gained), 32'(got.sync_gained));
          check_field("sync_dropped", 32'(want.sync_dropped), 32'(got.sync_dropped));
          check_field("engine_rpm", 32'(want.engine_rpm), 32'(got.engine_rpm));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // The result side stalls at random, and on request holds off for a long
  // stretch so that the block fills up and pushes back on its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // A hung block never produces another beat; end the run on that.
  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $error("no beat on any channel for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one tooth edge and returns at the edge where it is taken. Called
  // at a rising edge; valid stays high into the next beat unless an idle
  // gap is drawn, so it is never lowered and raised in the same step.
  task automatic send_tooth(input logic [31:0] stamp);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tooth_time <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering edges and waits until every expected beat is back, plus a
  // short tail. The first edge lets the scoreboard log the last beat taken.
  task automatic drain(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input crmtd_cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Rewrites all five registers once the block has gone idle.
  task automatic program_regs(input logic [15:0] min_p, input logic [15:0] ratio,
                              input logic [15:0] gaps, input logic [15:0] eff,
                              input logic [15:0] tpr);
    drain(SETTLE_CYCLES);
    write_reg(CFG_MIN_PERIOD, min_p);
    write_reg(CFG_GAP_RATIO, ratio);
    write_reg(CFG_GAPS_SYNC, gaps);
    write_reg(CFG_EFF_TEETH, eff);
    write_reg(CFG_TEETH_REV, tpr);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_reg(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(3))
      0: return lo[15:0];
      1: return hi[15:0];
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic int unsigned pick_tooth_period();
    int unsigned p;
    // Mostly engine-like speeds, now and then a very slow crank.
    if ($urandom_range(7) == 0)
      p = r_min_period + $urandom_range(60000);
    else
      p = r_min_period + $urandom_range(2000);
    return (p == 0) ? 1 : p;
  endfunction

  // Drives a trigger wheel under the current registers: runs of evenly spaced
  // teeth closed by a long missing-tooth period, so sync is gained and held.
  // Mixed in are noise spikes shorter than the minimum period, revolutions
  // whose gap is missing (which drops sync), early gaps, speed changes and
  // edges at random timestamps.
  task automatic spin_wheel(input int n_items);
    logic [31:0] stamp;
    int unsigned base_p, jit, gap_p, teeth_left, roll;
    stamp = $urandom;
    send_tooth(stamp);
    base_p = pick_tooth_period();
    teeth_left = r_eff_teeth - 1;
    for (int n = 1; n < n_items; n++) begin
      // Jitter is bounded so that no ordinary tooth reads as a gap.
      jit = (r_gap_ratio > 100) ? base_p * (r_gap_ratio - 100) / 200 : 0;
      gap_p = ((base_p + jit) * r_gap_ratio) / 100 + 1 + $urandom_range(base_p / 2);
      roll = $urandom_range(99);
      if (roll < 4) begin
        stamp = $urandom;
        send_tooth(stamp);
      end else if (roll < 11) begin
        send_tooth(stamp + $urandom_range(r_min_period - 1));
      end else if (teeth_left == 0 || roll < 14) begin
        if ($urandom_range(99) < 8) begin
          // Lost gap: one tooth too many, the block must drop sync.
          stamp = stamp + base_p + $urandom_range(jit);
        end else begin
          stamp = stamp + gap_p;
          teeth_left = r_eff_teeth - 1;
          if ($urandom_range(9) == 0)
            base_p = pick_tooth_period();
        end
        send_tooth(stamp);
      end else begin
        stamp = stamp + base_p + $urandom_range(jit);
        teeth_left--;
        send_tooth(stamp);
      end
    end
  endtask

  // Reset values, first edges with no previous period, noise just under the
  // minimum, two gaps to sync, then timestamps that wrap through zero.
  task automatic test_reset_defaults();
    send_tooth(32'd0);
    send_tooth(32'd189);
    send_tooth(32'd190);
    send_tooth(32'd380);
    send_tooth(32'd666);
    send_tooth(32'd856);
    send_tooth(32'd1456);
    send_tooth(32'd1656);
    send_tooth(32'hFFFF_FFFF);
    send_tooth(32'h0000_00FF);
    send_tooth(32'h0000_0163);
    send_tooth(32'h0000_0400);
  endtask

  // Register extremes: one-microsecond teeth with the rpm saturating, sync on
  // a single gap and lost after two teeth, then the longest minimum period.
  task automatic test_register_extremes();
    logic [31:0] stamp;
    program_regs(16'd1, 16'd1000, 16'd1, 16'd2, 16'd2);
    stamp = m_last_time;
    stamp += 1;  send_tooth(stamp);
    stamp += 1;  send_tooth(stamp);
    stamp += 11; send_tooth(stamp);
    stamp += 1;  send_tooth(stamp);
    stamp += 1;  send_tooth(stamp);
    program_regs(16'd65535, 16'd100, 16'd255, 16'd255, 16'd255);
    stamp = m_last_time;
    send_tooth(stamp + 32'd65534);
    send_tooth(stamp + 32'd65535);
  endtask

  // Zero sync threshold, zero tooth limit and zero teeth per revolution:
  // every gap syncs, every ordinary tooth drops sync, and rpm reads as top.
  task automatic test_zero_registers();
    logic [31:0] stamp;
    program_regs(16'd1, 16'd100, 16'd0, 16'd0, 16'd0);
    stamp = m_last_time;
    stamp += 5; send_tooth(stamp);
    stamp += 5; send_tooth(stamp);
    stamp += 6; send_tooth(stamp);
    stamp += 6; send_tooth(stamp);
    stamp += 7; send_tooth(stamp);
  endtask

  // With a 100 percent ratio every longer period is a gap, so a slowly
  // lengthening run drives the gap count to its ceiling and past it.
  task automatic test_gap_count_saturation();
    logic [31:0] stamp;
    int unsigned period;
    program_regs(16'd1, 16'd100, 16'd255, 16'd255, 16'd255);
    stamp = m_last_time;
    period = 16 + $urandom_range(200);
    for (int n = 0; n < 262; n++) begin
      period += $urandom_range(3, 1);
      stamp += period;
      send_tooth(stamp);
    end
  endtask

  task automatic test_random_wheel();
    for (int ph = 0; ph < 3; ph++) begin
      program_regs(pick_reg(1, 65535), pick_reg(100, 1000), pick_reg(1, 8),
                   pick_reg(2, 40), pick_reg(2, 255));
      spin_wheel(90);
    end
  endtask

  // A long stretch with both sides streaming at full rate.
  task automatic test_streaming();
    program_regs(16'd190, 16'd150, 16'd2, 16'd35, 16'd36);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    spin_wheel(150);
    src_idle_pct = 27;
    sink_idle_pct = 27;
  endtask

  // The receiver holds off while edges keep coming, so the input stalls.
  task automatic test_backpressure();
    program_regs(16'd100, 16'd200, 16'd1, 16'd12, 16'd12);
    hold_req = 1'b1;
    spin_wheel(60);
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_tooth_time <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MIN_PERIOD;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_zero_registers();
    test_gap_count_saturation();
    test_random_wheel();
    test_streaming();
    test_backpressure();

    drain(END_TAIL);
    if (expected_results.size() != 0) begin
      $error("%0d result beats never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
